[rtl/core/scsf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scsf_pkg: shared types and constants of the vertical seam finder
// Holds the item structs, command codes, register indices and size constants.
// ----------------------------------------------------------------------------
package scsf_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;

  localparam int unsigned CFG_WIDTH_IDX  = 0;
  localparam int unsigned CFG_HEIGHT_IDX = 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] gray_pixel;
    logic [8:0] read_row;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  seam_col;
    logic [19:0] seam_cost;
    logic        seam_ready;
  } out_item_t;

  // Status from the sequencer to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } seq_status_t;

endpackage
`default_nettype wire

[rtl/core/scsf_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scsf_seq: seam search sequencer
// Walks energy, cost, bottom-row scan and backtrack passes over the image
// with one shared compare/add unit, one memory access per step.
// ----------------------------------------------------------------------------
module scsf_seq #(
  parameter int unsigned MAX_WIDTH  = scsf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = scsf_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned XW = $clog2(MAX_WIDTH),
  localparam int unsigned YW = $clog2(MAX_HEIGHT),
  localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned CW = 11 + YW + 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [XW:0]  w,
  input  wire logic [YW:0]  h,
  // pixel load port
  input  wire logic         ld_en,
  input  wire logic [AW-1:0] ld_addr,
  input  wire logic [7:0]   ld_data,
  // seam read port
  input  wire logic [YW-1:0] rd_row,
  output logic [XW-1:0]     rd_col,
  output logic [CW-1:0]     best_cost,
  output scsf_pkg::seq_status_t status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EFET  = 4'd1;  // fetch one of nine neighbors
  localparam logic [3:0] S_EWR   = 4'd2;  // write energy
  localparam logic [3:0] S_CRD0  = 4'd3;  // read energy of (x,y)
  localparam logic [3:0] S_CFET  = 4'd4;  // fetch parent costs
  localparam logic [3:0] S_CWR   = 4'd5;  // write cost
  localparam logic [3:0] S_BFET  = 4'd6;  // scan bottom row
  localparam logic [3:0] S_TFET  = 4'd7;  // backtrack fetch
  localparam logic [3:0] S_TWR   = 4'd8;  // store seam entry
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [7:0]    gray_mem   [MAX_WIDTH*MAX_HEIGHT];
  logic [10:0]   energy_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [CW-1:0] cost_mem   [MAX_WIDTH*MAX_HEIGHT];
  logic [XW-1:0] seam_mem   [MAX_HEIGHT];

  logic [3:0]    state_r, state_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [3:0]    k_r, k_nxt;     // neighbor / phase index
  logic          kv_r, kv_nxt;   // read data valid for k_r-1
  logic signed [12:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic signed [12:0] gx_sum, gy_sum;
  logic [CW-1:0] acc_r, acc_nxt; // running minimum
  logic [XW-1:0] col_r, col_nxt;
  logic [XW-1:0] pcol_r, pcol_nxt;
  logic [10:0]   e_r, e_nxt;
  logic [CW-1:0] best_r, best_nxt;

  logic [7:0]    g_q;
  logic [10:0]   e_q;
  logic [CW-1:0] c_q;
  logic [XW-1:0] s_q;

  logic [AW-1:0] g_ra, e_ra, c_ra, e_wa, c_wa;
  logic          e_we, c_we, s_we;
  logic [10:0]   e_wd;
  logic [CW-1:0] c_wd;
  logic [YW-1:0] s_wa;
  logic [XW-1:0] s_wd;

  // neighbor offsets for the Sobel fetch and parent offsets for cost
  logic signed [XW+1:0] nx;
  logic signed [YW+1:0] ny;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [1:0]    tcol, trow;
  logic [1:0]    kk;
  logic [3:0]    kp;
  logic signed [12:0] gv;
  logic [XW:0]   wm1;
  logic [YW:0]   hm1;
  logic          cand_ok;
  logic [XW-1:0] cand_col;

  assign wm1 = w - 1'b1;
  assign hm1 = h - 1'b1;

  always_ff @(posedge clk) begin
    if (ld_en) gray_mem[ld_addr] <= ld_data;
    g_q <= gray_mem[g_ra];
    if (e_we) energy_mem[e_wa] <= e_wd;
    e_q <= energy_mem[e_ra];
    if (c_we) cost_mem[c_wa] <= c_wd;
    c_q <= cost_mem[c_ra];
    if (s_we) seam_mem[s_wa] <= s_wd;
    s_q <= seam_mem[rd_row];
  end

  assign rd_col    = s_q;
  assign best_cost = best_r;

  // Clamped neighbor coordinate for Sobel tap k (0..8, row-major 3x3).
  always_comb begin
    case (k_r)
      4'd0:    begin tcol = 2'd0; trow = 2'd0; end
      4'd1:    begin tcol = 2'd1; trow = 2'd0; end
      4'd2:    begin tcol = 2'd2; trow = 2'd0; end
      4'd3:    begin tcol = 2'd0; trow = 2'd1; end
      4'd4:    begin tcol = 2'd1; trow = 2'd1; end
      4'd5:    begin tcol = 2'd2; trow = 2'd1; end
      4'd6:    begin tcol = 2'd0; trow = 2'd2; end
      4'd7:    begin tcol = 2'd1; trow = 2'd2; end
      4'd8:    begin tcol = 2'd2; trow = 2'd2; end
      default: begin tcol = 2'd0; trow = 2'd0; end
    endcase
    nx = $signed({2'b00, x_r}) + $signed({{XW{1'b0}}, tcol}) - $signed((XW+2)'(1));
    ny = $signed({2'b00, y_r}) + $signed({{YW{1'b0}}, trow}) - $signed((YW+2)'(1));
    if (nx < 0) cx = '0;
    else if (nx > $signed({1'b0, wm1})) cx = wm1[XW-1:0];
    else cx = nx[XW-1:0];
    if (ny < 0) cy = '0;
    else if (ny > $signed({1'b0, hm1})) cy = hm1[YW-1:0];
    else cy = ny[YW-1:0];
  end

  // Parent candidate for phase kp: 0 up, 1 left, 2 right.
  always_comb begin
    kp = kv_r ? k_r - 4'd1 : 4'd0;
    kk = kp[1:0];
    case (kk)
      2'd1:    begin cand_col = pcol_r - 1'b1; cand_ok = (pcol_r != '0); end
      2'd2:    begin cand_col = pcol_r + 1'b1;
                     cand_ok = ({1'b0, pcol_r} != wm1); end
      default: begin cand_col = pcol_r; cand_ok = 1'b1; end
    endcase
  end

  // Sobel weight of the tap returned last cycle.
  always_comb begin
    gv = $signed({5'b0, g_q});
    gx_sum = gx_r;
    gy_sum = gy_r;
    case (kp)
      4'd0: begin gx_sum = gx_r + gv;       gy_sum = gy_r + gv;       end
      4'd1: begin                            gy_sum = gy_r + (gv <<< 1); end
      4'd2: begin gx_sum = gx_r - gv;       gy_sum = gy_r + gv;       end
      4'd3: begin gx_sum = gx_r + (gv <<< 1);                          end
      4'd5: begin gx_sum = gx_r - (gv <<< 1);                          end
      4'd6: begin gx_sum = gx_r + gv;       gy_sum = gy_r - gv;       end
      4'd7: begin                            gy_sum = gy_r - (gv <<< 1); end
      4'd8: begin gx_sum = gx_r - gv;       gy_sum = gy_r - gv;       end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; y_nxt = y_r; k_nxt = k_r; kv_nxt = 1'b0;
    gx_nxt = gx_r; gy_nxt = gy_r;
    acc_nxt = acc_r; col_nxt = col_r; pcol_nxt = pcol_r;
    e_nxt = e_r; best_nxt = best_r;
    g_ra = AW'(cy) * AW'(w) + AW'(cx);
    e_ra = AW'(y_r) * AW'(w) + AW'(x_r);
    c_ra = '0;
    e_we = 1'b0; e_wa = e_ra; e_wd = '0;
    c_we = 1'b0; c_wa = e_ra; c_wd = '0;
    s_we = 1'b0; s_wa = y_r; s_wd = col_r;
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_EFET; x_nxt = '0; y_nxt = '0; k_nxt = '0;
          gx_nxt = '0; gy_nxt = '0;
        end
      end
      S_EFET: begin
        kv_nxt = 1'b1;
        k_nxt  = k_r + 4'd1;
        if (!kv_r) begin
          gx_nxt = '0; gy_nxt = '0;
        end else begin
          gx_nxt = gx_sum; gy_nxt = gy_sum;
        end
        if (k_r == 4'd9) begin
          state_nxt = S_EWR; kv_nxt = 1'b0;
        end
      end
      S_EWR: begin
        e_we = 1'b1;
        e_wd = 11'((gx_r < 0 ? -gx_r : gx_r) + (gy_r < 0 ? -gy_r : gy_r));
        gx_nxt = '0; gy_nxt = '0; k_nxt = '0;
        if ({1'b0, x_r} == wm1) begin
          x_nxt = '0;
          if ({1'b0, y_r} == hm1) begin
            y_nxt = '0; state_nxt = S_CRD0;
          end else y_nxt = y_r + 1'b1;
          state_nxt = ({1'b0, y_r} == hm1) ? S_CRD0 : S_EFET;
        end else begin
          x_nxt = x_r + 1'b1; state_nxt = S_EFET;
        end
      end
      S_CRD0: begin
        // e_q valid next cycle; start parent fetch
        state_nxt = S_CFET; k_nxt = '0; pcol_nxt = x_r;
      end
      S_CFET: begin
        if (k_r == 4'd0) e_nxt = e_q;
        c_ra = AW'(y_r - 1'b1) * AW'(w) + AW'(cand_col);
        kv_nxt = 1'b1;
        k_nxt = k_r + 4'd1;
        if (kv_r && cand_ok && (kk == 2'd0 || c_q < acc_r)) acc_nxt = c_q;
        if (y_r == '0 || k_r == 4'd3) begin
          state_nxt = S_CWR; kv_nxt = 1'b0;
        end
        // issue the fetch for candidate k_r
        case (k_r[1:0])
          2'd1:    c_ra = AW'(y_r - 1'b1) * AW'(w) + AW'(pcol_r - 1'b1);
          2'd2:    c_ra = AW'(y_r - 1'b1) * AW'(w) + AW'(pcol_r + 1'b1);
          default: c_ra = AW'(y_r - 1'b1) * AW'(w) + AW'(pcol_r);
        endcase
      end
      S_CWR: begin
        c_we = 1'b1;
        c_wd = (y_r == '0) ? CW'(e_r) : CW'(e_r) + acc_r;
        if ({1'b0, x_r} == wm1) begin
          x_nxt = '0;
          if ({1'b0, y_r} == hm1) begin
            state_nxt = S_BFET; k_nxt = '0;
          end else begin
            y_nxt = y_r + 1'b1; state_nxt = S_CRD0;
          end
        end else begin
          x_nxt = x_r + 1'b1; state_nxt = S_CRD0;
        end
      end
      S_BFET: begin
        // address column x_r of the bottom row, compare last returned
        c_ra = AW'(hm1[YW-1:0]) * AW'(w) + AW'(x_r);
        kv_nxt = 1'b1;
        if (kv_r) begin
          if (col_r == '0 && pcol_r == '0 ? 1'b1 : c_q < acc_r) begin
            acc_nxt = c_q; col_nxt = pcol_r;
          end
        end
        pcol_nxt = x_r;
        if (!kv_r) col_nxt = '0;
        x_nxt = x_r + 1'b1;
        // stop once the last column's cost has been compared
        if (kv_r && {1'b0, pcol_r} == wm1) begin
          state_nxt = S_TWR; kv_nxt = 1'b0; y_nxt = hm1[YW-1:0];
        end
      end
      S_TWR: begin
        s_we = 1'b1;
        if (y_r == hm1[YW-1:0]) best_nxt = acc_r;
        if (y_r == '0) state_nxt = S_DONE;
        else begin
          y_nxt = y_r - 1'b1; pcol_nxt = col_r; k_nxt = '0;
          state_nxt = S_TFET;
        end
      end
      S_TFET: begin
        c_ra = AW'(y_r) * AW'(w) + AW'(cand_col);
        case (k_r[1:0])
          2'd1:    c_ra = AW'(y_r) * AW'(w) + AW'(pcol_r - 1'b1);
          2'd2:    c_ra = AW'(y_r) * AW'(w) + AW'(pcol_r + 1'b1);
          default: c_ra = AW'(y_r) * AW'(w) + AW'(pcol_r);
        endcase
        kv_nxt = 1'b1;
        k_nxt = k_r + 4'd1;
        if (kv_r && cand_ok && (kk == 2'd0 || c_q < acc_r)) begin
          acc_nxt = c_q; col_nxt = cand_col;
        end
        if (k_r == 4'd3) begin state_nxt = S_TWR; kv_nxt = 1'b0; end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kv_r    <= 1'b0;
      best_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kv_r    <= kv_nxt;
      best_r  <= best_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; k_r <= k_nxt;
    gx_r <= gx_nxt; gy_r <= gy_nxt;
    acc_r <= acc_nxt; col_r <= col_nxt; pcol_r <= pcol_nxt; e_r <= e_nxt;
  end

  assign status.busy = (state_r != S_IDLE);
  assign status.done = (state_r == S_DONE);

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> state_r == S_IDLE) else $error("search started while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> state_r == S_IDLE) else $error("done not followed by idle");
  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EFET |-> k_r <= 4'd9) else $error("tap index overrun");

endmodule
`default_nettype wire

[rtl/core/seam_carving_seam_finder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// seam_carving_seam_finder_unit: vertical minimum-energy seam finder
// Loads a grayscale image, then finds the cheapest vertical seam by DP.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | in        | start & !busy        | in_item  (cmd, gray_pixel, read_row)
//  out_    | out       | out_valid, one cycle | out_item (seam_col, seam_cost, seam_ready)
//  cfg_    | in        | APB write, pready=1  | image_width @0x0, image_height @0x4
//
// A pixel is stored as it is accepted. The load of the last pixel starts the
// seam search, which walks the image through one memory port per store: an
// energy pass, a cost pass, then the bottom-row scan and backtrack; busy stays
// high meanwhile. A read registers its row, then reads the registered seam
// memory, and gives its item after that; busy stays high until the item is given.
// Reset clears control state only; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module seam_carving_seam_finder_unit #(
  parameter int unsigned MAX_WIDTH  = scsf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = scsf_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire scsf_pkg::in_item_t in_item,
  output logic                    out_valid,
  output scsf_pkg::out_item_t     out_item,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned CW = 11 + YW + 1;

  logic [9:0]    width_r, height_r;
  logic [AW:0]   cnt_r;
  logic          ready_r;
  logic [1:0]    rd_pipe_r;
  logic [YW-1:0] rd_row_r;
  logic [XW:0]   w_eff;
  logic [YW:0]   h_eff;
  logic          cfg_wr, acc, ld, rd, last;
  logic [XW-1:0] rd_col;
  logic [CW-1:0] best_cost;
  logic [AW:0]   total;
  logic [9:0]    row_cl;
  scsf_pkg::seq_status_t st;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] ? {22'd0, height_r} : {22'd0, width_r});

  // Clamp register values to the supported range.
  always_comb begin
    if (width_r == '0) w_eff = (XW+1)'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = (XW+1)'(MAX_WIDTH);
    else w_eff = (XW+1)'(width_r);
    if (height_r == '0) h_eff = (YW+1)'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = (YW+1)'(MAX_HEIGHT);
    else h_eff = (YW+1)'(height_r);
  end

  assign total = (AW+1)'(w_eff) * (AW+1)'(h_eff);
  assign busy  = st.busy | (rd_pipe_r != '0);
  assign acc   = start & ~busy;
  assign ld    = acc & (in_item.cmd == scsf_pkg::CMD_LOAD);
  assign rd    = acc & (in_item.cmd == scsf_pkg::CMD_READ);
  assign last  = ld & (cnt_r + 1'b1 >= total);

  // Clamp the read row to the last image row.
  assign row_cl = (10'(in_item.read_row) > 10'(h_eff - 1'b1)) ?
                  10'(h_eff - 1'b1) : 10'(in_item.read_row);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 10'd512;
      height_r  <= 10'd512;
      cnt_r     <= '0;
      ready_r   <= 1'b0;
      rd_pipe_r <= '0;
    end else begin
      rd_pipe_r <= {rd_pipe_r[0], rd};
      if (cfg_wr && pready) begin
        if (paddr == 3'(4 * scsf_pkg::CFG_WIDTH_IDX)) begin
          width_r <= pwdata[9:0]; cnt_r <= '0; ready_r <= 1'b0;
        end else if (paddr == 3'(4 * scsf_pkg::CFG_HEIGHT_IDX)) begin
          height_r <= pwdata[9:0]; cnt_r <= '0; ready_r <= 1'b0;
        end
      end else if (ld) begin
        // hold ready off from the first pixel of a new image
        if (cnt_r == '0) ready_r <= 1'b0;
        cnt_r <= last ? '0 : cnt_r + 1'b1;
      end
      if (st.done) ready_r <= 1'b1;
    end
    if (rd) rd_row_r <= row_cl[YW-1:0];
  end

  scsf_seq #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_seq (
    .clk(clk), .rst_n(rst_n), .go(last), .w(w_eff), .h(h_eff),
    .ld_en(ld), .ld_addr(cnt_r[AW-1:0]), .ld_data(in_item.gray_pixel),
    .rd_row(rd_row_r), .rd_col(rd_col), .best_cost(best_cost), .status(st)
  );

  // Present a read result for exactly one cycle.
  assign out_valid           = rd_pipe_r[1];
  assign out_item.seam_col   = ready_r ? 9'(rd_col) : 9'd0;
  assign out_item.seam_cost  = ready_r ? 20'(best_cost) : 20'd0;
  assign out_item.seam_ready = ready_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st.busy |-> !acc) else $error("item taken during search");
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held longer than a cycle");
  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    st.done |=> ready_r) else $error("ready not set after search");

endmodule
`default_nettype wire

[sim/seam_carving_seam_finder_unit_test.sv]
// ----------------------------------------------------------------------------
// seam_carving_seam_finder_unit_test: self-checking bench of the seam finder
// Loads images of many sizes through the command port, reads back seam
// columns and cost, and checks every result against an in-bench predictor.
// ----------------------------------------------------------------------------
module seam_carving_seam_finder_unit_test;

  localparam int PIX_MAX   = 512;
  localparam int WDOG_MAX  = 200000;
  localparam int ITEM_GOAL = 1950;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  scsf_pkg::in_item_t  in_item = '0;
  logic        out_valid;
  scsf_pkg::out_item_t out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  seam_carving_seam_finder_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Pending items for the driver, and seam results still owed by the block.
  scsf_pkg::in_item_t  pending_items[$];
  scsf_pkg::out_item_t seam_results_due[$];
  int        items_sent = 0;
  int        fail_count = 0;
  int        quiet_cycles = 0;
  logic      took = 1'b0;

  // Predictor copy of registers and image state.
  int        img_w_reg = 512;
  int        img_h_reg = 512;
  int        load_cnt = 0;
  int        seam_total = 0;
  logic      seam_valid = 1'b0;
  logic [7:0] gray_mem[PIX_MAX*PIX_MAX];
  int        energy_mem[PIX_MAX*PIX_MAX];
  int        cost_mem[PIX_MAX*PIX_MAX];
  int        seam_mem[PIX_MAX];

  // Append one item to the driver's queue.
  function automatic void add_pending(scsf_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Apply the register decode: zero acts as one, oversize clamps to max.
  function automatic int eff_dim(int v);
    if (v == 0) return 1;
    return (v > PIX_MAX) ? PIX_MAX : v;
  endfunction

  function automatic int gray_at(int x, int y, int w, int h);
    if (x < 0) x = 0;
    if (x > w - 1) x = w - 1;
    if (y < 0) y = 0;
    if (y > h - 1) y = h - 1;
    return int'(gray_mem[y*w + x]);
  endfunction

  // Sobel energy, cumulative cost map, bottom-row pick and backtrack.
  task automatic find_min_seam(int w, int h);
    int gx, gy, m, col, p, bv;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        gx = gray_at(x-1, y-1, w, h) - gray_at(x+1, y-1, w, h)
           + 2 * (gray_at(x-1, y, w, h) - gray_at(x+1, y, w, h))
           + gray_at(x-1, y+1, w, h) - gray_at(x+1, y+1, w, h);
        gy = gray_at(x-1, y-1, w, h) + 2 * gray_at(x, y-1, w, h)
           + gray_at(x+1, y-1, w, h)
           - gray_at(x-1, y+1, w, h) - 2 * gray_at(x, y+1, w, h)
           - gray_at(x+1, y+1, w, h);
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        energy_mem[y*w + x] = gx + gy;
      end
    end
    for (int x = 0; x < w; x++) cost_mem[x] = energy_mem[x];
    for (int y = 1; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        m = cost_mem[(y-1)*w + x];
        if (x > 0 && cost_mem[(y-1)*w + x-1] < m) m = cost_mem[(y-1)*w + x-1];
        if (x < w-1 && cost_mem[(y-1)*w + x+1] < m) m = cost_mem[(y-1)*w + x+1];
        cost_mem[y*w + x] = energy_mem[y*w + x] + m;
      end
    end
    // Lowest index wins ties on the bottom row.
    col = 0;
    seam_total = cost_mem[(h-1)*w];
    for (int x = 1; x < w; x++) begin
      if (cost_mem[(h-1)*w + x] < seam_total) begin
        seam_total = cost_mem[(h-1)*w + x];
        col = x;
      end
    end
    seam_mem[h-1] = col;
    // Prefer straight up, then strictly smaller left, then right.
    for (int y = h - 2; y >= 0; y--) begin
      p = col;
      bv = cost_mem[y*w + p];
      if (p > 0 && cost_mem[y*w + p-1] < bv) begin
        bv = cost_mem[y*w + p-1];
        col = p - 1;
      end
      if (p < w-1 && cost_mem[y*w + p+1] < bv) col = p + 1;
      seam_mem[y] = col;
    end
    seam_valid = 1'b1;
  endtask

  // Advance the predictor by one accepted item; queue any result it owes.
  task automatic predict_item(scsf_pkg::in_item_t it);
    int w, h, row;
    scsf_pkg::out_item_t r;
    w = eff_dim(img_w_reg);
    h = eff_dim(img_h_reg);
    if (it.cmd == scsf_pkg::CMD_LOAD) begin
      if (load_cnt >= w*h) load_cnt = 0;
      if (load_cnt == 0) seam_valid = 1'b0;
      gray_mem[load_cnt] = it.gray_pixel;
      load_cnt++;
      if (load_cnt >= w*h) begin
        load_cnt = 0;
        find_min_seam(w, h);
      end
    end else begin
      r = '0;
      if (seam_valid) begin
        row = int'(it.read_row);
        if (row > h - 1) row = h - 1;
        r.seam_col   = 9'(seam_mem[row]);
        r.seam_cost  = 20'(seam_total);
        r.seam_ready = 1'b1;
      end
      seam_results_due.insert(seam_results_due.size(), r);
    end
  endtask

  // Accept items and results at the rising edge; check in order.
  always @(posedge clk) begin
    scsf_pkg::out_item_t want;
    if (rst_n && start && !busy) begin
      predict_item(in_item);
      items_sent <= items_sent + 1;
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
    if (rst_n && out_valid) begin
      if (seam_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_item);
        fail_count++;
      end else begin
        want = seam_results_due.pop_front();
        if (out_item.seam_col !== want.seam_col) begin
          $display("%0t: seam_col expected %0d got %0d", $time, want.seam_col,
                   out_item.seam_col);
          fail_count++;
        end
        if (out_item.seam_cost !== want.seam_cost) begin
          $display("%0t: seam_cost expected %0d got %0d", $time, want.seam_cost,
                   out_item.seam_cost);
          fail_count++;
        end
        if (out_item.seam_ready !== want.seam_ready) begin
          $display("%0t: seam_ready expected %0b got %0b", $time, want.seam_ready,
                   out_item.seam_ready);
          fail_count++;
        end
      end
    end
    // Watchdog: count cycles with no traffic at all.
    if (rst_n && !(start && !busy) && !out_valid) quiet_cycles++;
    else quiet_cycles = 0;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("seam_carving_seam_finder_unit regression: fail");
      $finish;
    end
  end

  // Drive at the falling edge. Hold the item until accepted, then advance.
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (items_sent < 650) ? 25 : (items_sent < 1300) ? 65 : 0;
    if (rst_n && (!start || took)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Wait until everything is drained and the seam search has finished.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || start || seam_results_due.size() != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic cfg_write(int idx, logic [9:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * idx);
    // Upper bits are don't-care to the block; scramble them.
    pwdata  <= {22'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == scsf_pkg::CFG_WIDTH_IDX) img_w_reg = int'(value);
    else img_h_reg = int'(value);
    load_cnt   = 0;
    seam_valid = 1'b0;
  endtask

  function automatic scsf_pkg::in_item_t make_read(int row);
    scsf_pkg::in_item_t it;
    it.cmd        = scsf_pkg::CMD_READ;
    it.gray_pixel = 8'($urandom);
    it.read_row   = 9'(row);
    return it;
  endfunction

  function automatic scsf_pkg::in_item_t make_load(logic [7:0] pix);
    scsf_pkg::in_item_t it;
    it.cmd        = scsf_pkg::CMD_LOAD;
    it.gray_pixel = pix;
    it.read_row   = 9'($urandom);
    return it;
  endfunction

  // Queue one full image with reads sprinkled in and a burst of reads after.
  task automatic queue_image(int w, int h, int pix_mode, int n_reads);
    logic [7:0] pix;
    for (int i = 0; i < w*h; i++) begin
      case (pix_mode)
        0: pix = 8'($urandom);
        1: pix = 8'h00;
        2: pix = 8'hFF;
        default: pix = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
      add_pending(make_load(pix));
      // Mid-load reads must come back not ready.
      if ($urandom_range(15) == 0) add_pending(make_read($urandom_range(511)));
    end
    for (int i = 0; i < n_reads; i++) begin
      if ($urandom_range(3) == 0) add_pending(make_read($urandom_range(511)));
      else add_pending(make_read($urandom_range(h - 1)));
    end
  endtask

  task automatic new_size(logic [9:0] wv, logic [9:0] hv);
    wait_drained();
    cfg_write(scsf_pkg::CFG_WIDTH_IDX, wv);
    cfg_write(scsf_pkg::CFG_HEIGHT_IDX, hv);
  endtask

  initial begin
    int w, h, rem;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: read before any image, read row extremes, 1x1 via zero sizes.
    add_pending(make_read(0));
    add_pending(make_read(511));
    new_size(10'd0, 10'd0);
    queue_image(1, 1, 2, 2);
    // Oversize width clamps to max with a single row.
    new_size(10'h3FF, 10'd1);
    queue_image(512, 1, 0, 3);
    // Oversize height clamps to max with a single column.
    new_size(10'd1, 10'h3FF);
    queue_image(1, 512, 0, 3);
    new_size(10'd512, 10'd2);
    add_pending(make_read(0));
    queue_image(3, 1, 1, 0);   // partial image: stays not ready
    add_pending(make_read(1));
    new_size(10'd3, 10'd2);
    queue_image(3, 2, 3, 3);
    // Second image under the same size restarts loading.
    queue_image(3, 2, 0, 2);

    // Random images, mostly small; shrink the last one to fit the item budget.
    while (items_sent + pending_items.size() < ITEM_GOAL) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      h = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      rem = ITEM_GOAL - (items_sent + pending_items.size());
      if (w * h > rem) begin
        h = 1;
        if (w > rem) w = rem;
      end
      new_size(10'(w), 10'(h));
      queue_image(w, h, ($urandom_range(5) == 0) ? $urandom_range(3) : 0,
                  $urandom_range(2, 12));
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("seam_carving_seam_finder_unit regression: pass");
    end else begin
      $display("seam_carving_seam_finder_unit regression: fail");
    end
    $finish;
  end
endmodule
